// ----- rtl/core/longest_window_under_budget_max_defines.svh -----
// Assertion macros used by the block's top-level RTL file
`ifndef LONGEST_WINDOW_UNDER_BUDGET_MAX_DEFINES_SVH
`define LONGEST_WINDOW_UNDER_BUDGET_MAX_DEFINES_SVH

// Check a property outside reset
`define LWUB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included
`define LWUB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/lwub_pkg.sv -----
// Shared types, constants and helpers of the window search block
package lwub_pkg;

  localparam int VW       = 32;
  localparam int BUDGET_W = 36;
  localparam int COL_W    = 3;
  localparam int IN_COLS  = 5;

  // configuration register indexes
  localparam logic REG_BUDGET  = 1'b0;
  localparam logic REG_COLUMNS = 1'b1;

  typedef struct packed {
    logic                start;
    logic [COL_W-1:0]    cols;
    logic [BUDGET_W-1:0] budget;
  } srch_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
  } srch_stat_t;

  function automatic logic [VW-1:0] umax(input logic [VW-1:0] a, input logic [VW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- rtl/core/lwub_ifs.sv -----
// Valid/ready channels for rows in and column results out
interface lwub_row_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_col1;
  logic [31:0] value_col2;
  logic [31:0] value_col3;
  logic [31:0] value_col4;
  logic [31:0] value_col5;
  logic        last_row;
  modport source (output valid, value_col1, value_col2, value_col3, value_col4,
                  value_col5, last_row, input ready);
  modport sink (input valid, value_col1, value_col2, value_col3, value_col4,
                value_col5, last_row, output ready);
endinterface

interface lwub_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] column_max;
  logic [2:0]  column_number;
  logic        last;
  modport source (output valid, column_max, column_number, last, input ready);
  modport sink (input valid, column_max, column_number, last, output ready);
endinterface

// ----- rtl/core/lwub_ram.sv -----
// Simple dual-port memory with registered read
module lwub_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lwub_search.sv -----
// Binary search over window length with block prefix/suffix maxima per probe
module lwub_search #(
  parameter int MAX_ROWS = 4096,
  parameter int NCOLS = 5,
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = $clog2(MAX_ROWS + 1),
  localparam int DW = NCOLS * lwub_pkg::VW
) (
  input  logic                clk,
  input  logic                rst,
  input  lwub_pkg::srch_cmd_t cmd,
  input  logic [CW-1:0]       n,
  output logic                row_re,
  output logic [AW-1:0]       row_raddr,
  input  logic [DW-1:0]       row_rdata,
  output lwub_pkg::srch_stat_t stat,
  output logic [DW-1:0]       best
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MID  = 4'd1;
  localparam logic [3:0] B_RD   = 4'd2;
  localparam logic [3:0] B_WR   = 4'd3;
  localparam logic [3:0] F_RD1  = 4'd4;
  localparam logic [3:0] F_RD2  = 4'd5;
  localparam logic [3:0] F_EV   = 4'd6;
  localparam logic [3:0] F_SUM  = 4'd7;

  localparam int VW = lwub_pkg::VW;

  logic [3:0]    state;
  logic [CW-1:0] lo, hi, len, i, k, nreg;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] s;
  logic [CW:0]   i_inc;
  logic          last_i;
  logic [DW-1:0] suf_prev, suf_new, pre, pre_next, wmax, wmax_next;
  logic [DW:0]   suf_q;
  logic          suf_we, suf_re;
  logic [AW-1:0] suf_raddr;
  logic          blk_start;
  logic [lwub_pkg::BUDGET_W-1:0] sum;

  assign mid_sum = {1'b0, lo} + {1'b0, hi} + {{CW{1'b0}}, 1'b1};
  assign mid     = mid_sum[CW:1];
  assign i_inc   = {1'b0, i} + {{CW{1'b0}}, 1'b1};
  assign s       = i_inc[CW-1:0] - len;
  assign last_i  = (i_inc[CW-1:0] == nreg);
  assign blk_start = (k == len - {{(CW-1){1'b0}}, 1'b1}) || (i == '0);

  // per-column maxima for the three passes
  always_comb begin
    for (int c = 0; c < NCOLS; c++) begin
      suf_new[c*VW +: VW]  = (k == '0) ? row_rdata[c*VW +: VW]
                           : lwub_pkg::umax(row_rdata[c*VW +: VW], suf_prev[c*VW +: VW]);
      pre_next[c*VW +: VW] = suf_q[DW] ? row_rdata[c*VW +: VW]
                           : lwub_pkg::umax(pre[c*VW +: VW], row_rdata[c*VW +: VW]);
      wmax_next[c*VW +: VW] = lwub_pkg::umax(suf_q[c*VW +: VW], pre[c*VW +: VW]);
    end
  end

  // sum the window maxima of the columns in use
  always_comb begin
    sum = '0;
    for (int c = 0; c < NCOLS; c++) begin
      if (c[lwub_pkg::COL_W-1:0] < cmd.cols) begin
        sum = sum + {{(lwub_pkg::BUDGET_W-VW){1'b0}}, wmax[c*VW +: VW]};
      end
    end
  end

  // memory port control
  assign row_re    = (state == B_RD) || (state == F_RD1);
  assign row_raddr = i[AW-1:0];
  assign suf_we    = (state == B_WR);
  assign suf_re    = (state == F_RD1) || (state == F_RD2);
  assign suf_raddr = (state == F_RD2) ? s[AW-1:0] : i[AW-1:0];

  lwub_ram #(.WIDTH(DW + 1), .DEPTH(MAX_ROWS)) u_suf (
    .clk   (clk),
    .we    (suf_we),
    .waddr (i[AW-1:0]),
    .wdata ({blk_start, suf_new}),
    .re    (suf_re),
    .raddr (suf_raddr),
    .rdata (suf_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stat.done  <= 1'b0;
      stat.found <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            lo    <= '0;
            hi    <= n;
            nreg  <= n;
            state <= S_MID;
          end
        end
        S_MID: begin
          if (lo < hi) begin
            len   <= mid;
            i     <= nreg - {{(CW-1){1'b0}}, 1'b1};
            k     <= '0;
            state <= B_RD;
          end else begin
            stat.done  <= 1'b1;
            stat.found <= (lo != '0);
            state      <= S_IDLE;
          end
        end
        B_RD: state <= B_WR;
        B_WR: begin
          suf_prev <= suf_new;
          k <= blk_start ? '0 : k + {{(CW-1){1'b0}}, 1'b1};
          if (i == '0) begin
            state <= F_RD1;
          end else begin
            i     <= i - {{(CW-1){1'b0}}, 1'b1};
            state <= B_RD;
          end
        end
        F_RD1: state <= F_RD2;
        F_RD2: begin
          pre <= pre_next;
          if (i_inc[CW-1:0] >= len) begin
            state <= F_EV;
          end else if (last_i) begin
            hi    <= len - {{(CW-1){1'b0}}, 1'b1};
            state <= S_MID;
          end else begin
            i     <= i_inc[CW-1:0];
            state <= F_RD1;
          end
        end
        F_EV: begin
          wmax  <= wmax_next;
          state <= F_SUM;
        end
        F_SUM: begin
          if (sum <= cmd.budget) begin
            lo    <= len;
            best  <= wmax;
            state <= S_MID;
          end else if (last_i) begin
            hi    <= len - {{(CW-1){1'b0}}, 1'b1};
            state <= S_MID;
          end else begin
            i     <= i_inc[CW-1:0];
            state <= F_RD1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/longest_window_under_budget_max.sv -----
// Top level: row loading, configuration registers and result output
//
// Rows enter on the rows channel, one transfer per cycle while loading, and
// are written to the row memory in arrival order; rows past MAX_ROWS are
// dropped but a dropped final row still starts the search. The transfer with
// last_row set starts a binary search for the longest window of consecutive
// rows whose sum of column maxima stays within budget. Each probe of length L
// makes a backward pass, reading each row in turn, that builds block suffix
// maxima in a second memory, and a forward pass that reads each row, takes
// and sums the window maxima once the window fills, and stops at the first
// fitting window. Each memory has a single read port. Rows are not taken
// during the search or the output phase. Results then leave on the results
// channel, one column per transfer, in column order, the final one marked by
// last; a stalled receiver holds the current result. After the final result
// the block takes rows for the next batch. Reset empties the row count, sets
// budget to zero and columns_used to five. Configuration writes take effect
// at once and are to be made only while the block is idle; the block itself
// does not enforce this.
module longest_window_under_budget_max #(
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLUMNS = 5,
  localparam int NCOLS = (MAX_COLUMNS < lwub_pkg::IN_COLS) ? MAX_COLUMNS : lwub_pkg::IN_COLS,
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = $clog2(MAX_ROWS + 1),
  localparam int DW = NCOLS * lwub_pkg::VW
) (
  input  logic                          clk,
  input  logic                          rst,
  lwub_row_if.sink                      rows,
  lwub_res_if.source                    results,
  input  logic                          write_enable,
  input  logic                          reg_index,
  input  logic [lwub_pkg::BUDGET_W-1:0] write_data
);

  `include "longest_window_under_budget_max_defines.svh"

  localparam logic [1:0] T_LOAD = 2'd0;
  localparam logic [1:0] T_SRCH = 2'd1;
  localparam logic [1:0] T_OUT  = 2'd2;

  localparam int VW = lwub_pkg::VW;

  logic [1:0]                    state;
  logic [CW-1:0]                 cnt;
  logic [lwub_pkg::BUDGET_W-1:0] budget;
  logic [lwub_pkg::COL_W-1:0]    columns_used, cols, oc;
  logic                          start, found;
  logic [lwub_pkg::IN_COLS-1:0][VW-1:0] vin;
  logic [DW-1:0]                 wdata, row_q, best;
  logic                          row_we, row_re;
  logic [AW-1:0]                 row_raddr;
  logic                          take;
  logic [VW-1:0]                 colmax;
  lwub_pkg::srch_cmd_t           cmd;
  lwub_pkg::srch_stat_t          stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      budget       <= '0;
      columns_used <= 3'd5;
    end else if (write_enable) begin
      case (reg_index)
        lwub_pkg::REG_BUDGET:  budget <= write_data;
        lwub_pkg::REG_COLUMNS: columns_used <= write_data[lwub_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the column count to between one and the stored columns
  always_comb begin
    if (columns_used == '0) begin
      cols = 3'd1;
    end else if (columns_used > NCOLS[lwub_pkg::COL_W-1:0]) begin
      cols = NCOLS[lwub_pkg::COL_W-1:0];
    end else begin
      cols = columns_used;
    end
  end

  // pack the incoming row
  assign vin = {rows.value_col5, rows.value_col4, rows.value_col3,
                rows.value_col2, rows.value_col1};
  always_comb begin
    for (int c = 0; c < NCOLS; c++) begin
      wdata[c*VW +: VW] = vin[c];
    end
  end

  assign rows.ready = (state == T_LOAD);
  assign take       = rows.valid && rows.ready;
  assign row_we     = take && (cnt < MAX_ROWS[CW-1:0]);

  lwub_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (cnt[AW-1:0]),
    .wdata (wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_q)
  );

  assign cmd.start  = start;
  assign cmd.cols   = cols;
  assign cmd.budget = budget;

  lwub_search #(.MAX_ROWS(MAX_ROWS), .NCOLS(NCOLS)) u_search (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .n         (cnt),
    .row_re    (row_re),
    .row_raddr (row_raddr),
    .row_rdata (row_q),
    .stat      (stat),
    .best      (best)
  );

  // select the current column's maximum
  always_comb begin
    colmax = '0;
    for (int c = 0; c < NCOLS; c++) begin
      if (oc == c[lwub_pkg::COL_W-1:0]) begin
        colmax = best[c*VW +: VW];
      end
    end
  end

  assign results.valid         = (state == T_OUT);
  assign results.column_max    = found ? colmax : '0;
  assign results.column_number = oc;
  assign results.last          = (oc == cols - 3'd1);

  // load, search and output sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_LOAD;
      cnt   <= '0;
      start <= 1'b0;
      found <= 1'b0;
      oc    <= '0;
    end else begin
      start <= 1'b0;
      case (state)
        T_LOAD: begin
          if (row_we) begin
            cnt <= cnt + {{(CW-1){1'b0}}, 1'b1};
          end
          if (take && rows.last_row) begin
            start <= 1'b1;
            state <= T_SRCH;
          end
        end
        T_SRCH: begin
          if (stat.done) begin
            found <= stat.found;
            oc    <= '0;
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (results.ready) begin
            if (results.last) begin
              cnt   <= '0;
              state <= T_LOAD;
            end else begin
              oc <= oc + 3'd1;
            end
          end
        end
        default: state <= T_LOAD;
      endcase
    end
  end

  `LWUB_ASSERT(a_no_overlap, rows.ready |-> !results.valid, "row taken during output")
  `LWUB_ASSERT(a_back_to_load,
    (results.valid && results.ready && results.last) |=> (rows.ready && cnt == '0),
    "batch not closed after last result")
  `LWUB_ASSERT(a_col_range, results.valid |-> (results.column_number < cols),
    "result column beyond columns in use")
  `LWUB_ASSERT(a_cnt_bound, rows.ready |-> (cnt <= MAX_ROWS[CW-1:0]), "row count past capacity")

endmodule
